[rtl/waypoint_heading_steering_macros.svh]
// Assertion macros shared by the waypoint steering RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WAYPOINT_HEADING_STEERING_MACROS_SVH
`define WAYPOINT_HEADING_STEERING_MACROS_SVH

// Check on every rising edge outside reset.
`define WHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every rising edge, reset included.
`define WHS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[rtl/whs_pkg.sv]
// Shared constants, types and helper functions for the waypoint steering block.
// No dependencies; used by whs_cordic, whs_mul and waypoint_heading_steering.
package whs_pkg;

	localparam int CORDIC_STEPS = 14;
	localparam int TAB_LEN      = 20;
	localparam int STEP_W       = 5;
	localparam int VEC_W        = 17;
	localparam int CRD_W        = 32;
	localparam int SCALE_SH     = 12;
	localparam int ANG_W        = 21;
	localparam int DIFF_W       = 22;
	localparam int MUL_W        = 19;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int SUMSQ_W      = 34;
	localparam int SAT_W        = 19;
	localparam int RND_SH       = 6;
	localparam int CFG_IDX_W    = 3;

	localparam logic signed [DIFF_W-1:0] ANG_PI  = 22'sd205887;
	localparam logic signed [DIFF_W-1:0] ANG_2PI = 22'sd411775;

	localparam logic [15:0] ATAN_TAB [TAB_LEN] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091,
		16'd2047, 16'd1024, 16'd512, 16'd256, 16'd128,
		16'd64, 16'd32, 16'd16, 16'd8, 16'd4,
		16'd2, 16'd1, 16'd1, 16'd0, 16'd0
	};

	localparam logic signed [15:0] RST_TARGET_X  = 16'sd4301;
	localparam logic signed [15:0] RST_TARGET_Z  = 16'sd2253;
	localparam logic [14:0]        RST_TOLERANCE = 15'd102;
	localparam logic signed [15:0] RST_OFFSET    = -16'sd657;
	localparam logic [3:0]         RST_GAIN      = 4'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_X  = 3'd0,
		CFG_TARGET_Z  = 3'd1,
		CFG_TOLERANCE = 3'd2,
		CFG_OFFSET    = 3'd3,
		CFG_GAIN      = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQZ,
		S_SQT,
		S_CMP,
		S_CRD1,
		S_CRD2,
		S_WRAP,
		S_GAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} crd_stat_t;

	function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(32'sd32767);
		lo = SAT_W'(-32'sd32768);
		priority if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

[rtl/whs_cordic.sv]
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, angle in Q.16 rad.
// Depends on whs_pkg for widths, the arctangent table and the status struct.
module whs_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [whs_pkg::VEC_W-1:0]  vec_x,
	input  logic signed [whs_pkg::VEC_W-1:0]  vec_y,
	output whs_pkg::crd_stat_t                stat,
	output logic signed [whs_pkg::ANG_W-1:0]  angle
);
	import whs_pkg::*;

	logic signed [CRD_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [STEP_W-1:0]       i_q;
	logic                    busy_q, done_q, zero_q;

	logic signed [CRD_W-1:0] xl, yl, xs, ys;
	logic signed [ANG_W-1:0] at;

	always_comb begin
		xl = CRD_W'(vec_x) <<< SCALE_SH;
		yl = CRD_W'(vec_y) <<< SCALE_SH;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = ANG_W'(ATAN_TAB[i_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// fold the left half-plane onto the right one, then rotate toward the x axis
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			zero_q <= (vec_x == '0) && (vec_y == '0);
			if (vec_x < 0) begin
				x_q <= -xl;
				y_q <= -yl;
				z_q <= (vec_y >= 0) ? ANG_W'(ANG_PI) : -ANG_W'(ANG_PI);
			end else begin
				x_q <= xl;
				y_q <= yl;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign angle     = zero_q ? '0 : z_q;

endmodule

[rtl/whs_mul.sv]
// Shared signed multiplier with registered product.
// Depends on whs_pkg for operand and product widths.
module whs_mul (
	input  logic                               clk,
	input  logic signed [whs_pkg::MUL_W-1:0]   op_a,
	input  logic signed [whs_pkg::MUL_W-1:0]   op_b,
	output logic signed [whs_pkg::PROD_W-1:0]  prod
);
	import whs_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

[rtl/waypoint_heading_steering.sv]
// Top level: sequencer, config registers and output register of the waypoint steering block.
// Depends on whs_pkg, whs_cordic, whs_mul and waypoint_heading_steering_macros.svh.
//
// Usage:
//   Input beats (pos_x, pos_z, north_x, north_z) arrive on in_valid/in_ready. Each beat
//   yields exactly one output beat (left_speed, right_speed, arrived) on out_valid/out_ready.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, indexes above the list are dropped. Write them only while the block is idle.
//   An input beat runs through S_SQX, S_SQZ, S_SQT, S_CMP, the two CORDIC runs (S_CRD1,
//   S_CRD2), S_WRAP, which repeats while the angle difference needs wrapping, S_GAIN and
//   S_DONE before out_valid; a new input beat is taken once the sequencer is back in S_IDLE.
//   One CORDIC unit resolves both angles one after the other, one step a cycle, and a single
//   multiplier forms the squared distance, the squared tolerance and the gain product. Once
//   the target is reached the angle work is skipped: S_CMP goes straight to S_DONE.
//   in_ready is high only between items, so one item is in flight at a time.
//   The output register frees the sequencer: in_ready returns while a result still waits;
//   a stalled receiver holds only the next item's final step.
//   Reset: registers take their default values, the arrival flag clears, no output pending.
//   The arrival flag is sticky: after it sets, every result is zero speed with arrived high.
module waypoint_heading_steering (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [whs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  pos_x,
	input  logic signed [15:0]                  pos_z,
	input  logic signed [15:0]                  north_x,
	input  logic signed [15:0]                  north_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  left_speed,
	output logic signed [15:0]                  right_speed,
	output logic                                arrived
);
	import whs_pkg::*;

	`include "waypoint_heading_steering_macros.svh"

	state_t state_q, state_d;

	logic signed [15:0] target_x_q, target_z_q, offset_q;
	logic [14:0]        tol_q;
	logic [3:0]         gain_q;
	logic               reached_q;

	logic signed [VEC_W-1:0]  dx_q, dz_q, fx_q, fz_q;
	logic [SUMSQ_W-1:0]       sumsq_q;
	logic signed [ANG_W-1:0]  z1_q;
	logic signed [DIFF_W-1:0] diff_q;

	logic               out_valid_q, out_arrived_q;
	logic signed [15:0] out_left_q, out_right_q;

	logic                     crd_start, load_out, near;
	logic signed [VEC_W-1:0]  crd_x, crd_y;
	crd_stat_t                crd_stat;
	logic signed [ANG_W-1:0]  crd_angle;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [DIFF_W-1:0] beta;
	logic signed [PROD_W-1:0] rnd;
	logic signed [SAT_W-1:0]  term, left_w, right_w;
	logic                     out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= RST_TARGET_X;
			target_z_q <= RST_TARGET_Z;
			tol_q      <= RST_TOLERANCE;
			offset_q   <= RST_OFFSET;
			gain_q     <= RST_GAIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TARGET_X:  target_x_q <= cfg_data;
				CFG_TARGET_Z:  target_z_q <= cfg_data;
				CFG_TOLERANCE: tol_q      <= cfg_data[14:0];
				CFG_OFFSET:    offset_q   <= cfg_data;
				CFG_GAIN:      gain_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	whs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crd_start),
		.vec_x  (crd_x),
		.vec_y  (crd_y),
		.stat   (crd_stat),
		.angle  (crd_angle)
	);

	whs_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign beta = diff_q - ANG_PI;
	assign near = sumsq_q < SUMSQ_W'(prod);

	// operand steering for the shared multiplier and CORDIC unit
	always_comb begin
		unique case (state_q)
			S_SQX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_SQZ: begin
				mul_a = MUL_W'(dz_q);
				mul_b = MUL_W'(dz_q);
			end
			S_SQT: begin
				mul_a = MUL_W'({1'b0, tol_q});
				mul_b = MUL_W'({1'b0, tol_q});
			end
			default: begin
				mul_a = MUL_W'({1'b0, gain_q});
				mul_b = beta[MUL_W-1:0];
			end
		endcase
		if (state_q == S_CMP) begin
			crd_x = dx_q;
			crd_y = dz_q;
		end else begin
			crd_x = fx_q;
			crd_y = fz_q;
		end
	end

	// rounding of gain*beta from Q.16 to Q.10 and the two wheel sums
	always_comb begin
		rnd     = prod + PROD_W'(32);
		term    = SAT_W'(rnd >>> RND_SH);
		left_w  = SAT_W'(offset_q) + term;
		right_w = SAT_W'(offset_q) - term;
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		crd_start = 1'b0;
		load_out  = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SQX;
				end
			end
			S_SQX: state_d = S_SQZ;
			S_SQZ: state_d = S_SQT;
			S_SQT: state_d = S_CMP;
			S_CMP: begin
				if (near || reached_q) begin
					state_d = S_DONE;
				end else begin
					crd_start = 1'b1;
					state_d   = S_CRD1;
				end
			end
			S_CRD1: begin
				if (crd_stat.done) begin
					crd_start = 1'b1;
					state_d   = S_CRD2;
				end
			end
			S_CRD2: begin
				if (crd_stat.done) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				if (!diff_q[DIFF_W-1] && diff_q < ANG_2PI) begin
					state_d = S_GAIN;
				end
			end
			S_GAIN: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= 1'b0;
		end else if (state_q == S_CMP && near) begin
			reached_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_q <= VEC_W'(target_x_q) - VEC_W'(pos_x);
			dz_q <= VEC_W'(target_z_q) - VEC_W'(pos_z);
			fx_q <= -VEC_W'(north_x);
			fz_q <= VEC_W'(north_z);
		end
		if (state_q == S_SQZ) begin
			sumsq_q <= SUMSQ_W'(prod);
		end else if (state_q == S_SQT) begin
			sumsq_q <= sumsq_q + SUMSQ_W'(prod);
		end
		if (state_q == S_CRD1 && crd_stat.done) begin
			z1_q <= crd_angle;
		end
		// bring the angle difference into [0, 2pi)
		if (state_q == S_CRD2 && crd_stat.done) begin
			diff_q <= DIFF_W'(z1_q) - DIFF_W'(crd_angle);
		end else if (state_q == S_WRAP) begin
			if (diff_q[DIFF_W-1]) begin
				diff_q <= diff_q + ANG_2PI;
			end else if (diff_q >= ANG_2PI) begin
				diff_q <= diff_q - ANG_2PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (reached_q) begin
				out_left_q    <= '0;
				out_right_q   <= '0;
				out_arrived_q <= 1'b1;
			end else begin
				out_left_q    <= sat16(left_w);
				out_right_q   <= sat16(right_w);
				out_arrived_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign left_speed  = out_left_q;
	assign right_speed = out_right_q;
	assign arrived     = out_arrived_q;

	`WHS_ASSERT(a_reached_sticky, reached_q |=> reached_q, "arrival flag cleared without reset")
	`WHS_ASSERT(a_arrived_stopped,
		out_valid_q && out_arrived_q |-> out_left_q == 0 && out_right_q == 0,
		"arrived beat carries nonzero speed")
	`WHS_ASSERT(a_crd_in_seq,
		crd_stat.busy |-> state_q == S_CRD1 || state_q == S_CRD2,
		"CORDIC unit busy outside the angle steps")
	`WHS_ASSERT(a_beta_wrapped,
		state_q == S_GAIN |-> !diff_q[DIFF_W-1] && diff_q < ANG_2PI,
		"heading difference not wrapped before gain step")
	`WHS_ASSERT_RST(a_reset_clean,
		!arst_n |-> state_q == S_IDLE && !out_valid_q && !reached_q,
		"control state not cleared in reset")

endmodule

[test/waypoint_heading_steering_test.sv]
// Self-checking bench for waypoint_heading_steering: a table walked row by row, directed
// or random register writes and samples, each checked against a local model or typed row.
// Depends on whs_pkg (register indexes) and the waypoint_heading_steering RTL.
module waypoint_heading_steering_test;
	import whs_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int LONG_HOLD      = 500;
	localparam int HOLD_AT_RESULT = 300;

	// first index past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

	localparam longint PI_Q16     = 205887;
	localparam longint TWO_PI_Q16 = 411775;
	localparam int     ATAN_LEN   = 20;
	localparam longint ATAN_Q16 [ATAN_LEN] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
		64, 32, 16, 8, 4, 2, 1, 1, 0, 0
	};
	localparam logic [15:0] CORNERS [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

	typedef struct packed {
		logic [15:0] px;
		logic [15:0] pz;
		logic [15:0] nx;
		logic [15:0] nz;
	} sample_t;

	typedef struct packed {
		logic [15:0] left_cmd;
		logic [15:0] right_cmd;
		logic        arrived;
	} wheel_cmd_t;

	typedef enum logic [2:0] {ROW_WRITE, ROW_PREDICT, ROW_TYPED, ROW_RANDOM, ROW_TAIL} row_kind_t;
	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [15:0]           data;
		logic [15:0]           px;
		logic [15:0]           pz;
		logic [15:0]           nx;
		logic [15:0]           nz;
		logic [15:0]           l;
		logic [15:0]           r;
		logic                  a;
	} plan_row_t;

	// kind, reg, data / count, pos_x, pos_z, north_x, north_z, left, right, arrived
	localparam int PLAN_ROWS = 37;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'h4000, 16'h0000, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h4000, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_SPARE, 16'h0000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_GAIN, 16'h0000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_TYPED, '0, '0, 16'h8000, 16'h7fff, 16'hc000, 16'h4000,
			16'hfd6f, 16'hfd6f, 1'b0},
		'{ROW_WRITE, CFG_OFFSET, 16'h7fff, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_TYPED, '0, '0, 16'h0000, 16'h0000, 16'h0064, 16'hff9c,
			16'h7fff, 16'h7fff, 1'b0},
		'{ROW_WRITE, CFG_GAIN, 16'h000f, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'h4000, 16'h0000, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'hc000, 16'h0000, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_OFFSET, 16'h8000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'hc000, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_TARGET_X, 16'h7fff, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_TARGET_Z, 16'h8000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h8000, 16'h7fff, 16'h4000, 16'h4000, '0, '0, 1'b0},
		// distance exactly equal to the tolerance: not yet arrived
		'{ROW_WRITE, CFG_TOLERANCE, 16'h0005, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h7ffc, 16'h8004, 16'h4000, 16'h0000, '0, '0, 1'b0},
		// zero tolerance lets the robot sit on the target: zero vector angle
		'{ROW_WRITE, CFG_TOLERANCE, 16'h0000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h7fff, 16'h8000, 16'h4000, 16'h0000, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, '0, '0, 1'b0},
		'{ROW_RANDOM, '0, 16'd230, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_RANDOM, '0, 16'd230, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_RANDOM, '0, 16'd230, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_RANDOM, '0, 16'd230, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_RANDOM, '0, 16'd230, '0, '0, '0, '0, '0, '0, 1'b0},
		// arrival is sticky, so it is exercised last
		'{ROW_WRITE, CFG_TOLERANCE, 16'h7fff, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_TARGET_X, 16'h0000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_TARGET_Z, 16'h0000, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_OFFSET, 16'h03e8, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_WRITE, CFG_GAIN, 16'h0006, '0, '0, '0, '0, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h7fff, 16'h7fff, 16'h4000, 16'h0000, '0, '0, 1'b0},
		'{ROW_PREDICT, '0, '0, 16'h8000, 16'h0000, 16'h0000, 16'h4000, '0, '0, 1'b0},
		'{ROW_TYPED, '0, '0, 16'h7ffe, 16'h0000, 16'h4000, 16'h0000,
			16'h0000, 16'h0000, 1'b1},
		'{ROW_TYPED, '0, '0, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 1'b1},
		'{ROW_TAIL, '0, 16'd30, '0, '0, '0, '0, '0, '0, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [15:0]   pos_x;
	logic signed [15:0]   pos_z;
	logic signed [15:0]   north_x;
	logic signed [15:0]   north_z;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [15:0]   left_speed;
	logic signed [15:0]   right_speed;
	logic                 arrived;

	// local copy of the block's registers and arrival flag
	logic [15:0] m_target_x = 16'h10cd;
	logic [15:0] m_target_z = 16'h08cd;
	logic [14:0] m_tolerance = 15'd102;
	logic [15:0] m_offset = 16'hfd6f;
	logic [3:0]  m_gain = 4'd6;
	logic        m_reached = 1'b0;

	wheel_cmd_t pending_wheels [$];
	wheel_cmd_t oldest;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int writes_done = 0;
	int saturated = 0;
	int arrivals_seen = 0;
	int stall_cycles = 0;

	waypoint_heading_steering DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_z       (pos_z),
		.north_x     (north_x),
		.north_z     (north_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.arrived     (arrived)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// atan2 by vectoring rotations, Q.16 radians
	function automatic longint heading_q16(input longint y, input longint x);
		longint ang;
		longint xs;
		longint ys;
		int iter;
		ang = 0;
		if (x == 0 && y == 0) begin
			return 0;
		end
		x = x * 4096;
		y = y * 4096;
		if (x < 0) begin
			ang = (y >= 0) ? PI_Q16 : -PI_Q16;
			x = -x;
			y = -y;
		end
		for (iter = 0; iter < CORDIC_STEPS && iter < ATAN_LEN; iter++) begin
			xs = x >>> iter;
			ys = y >>> iter;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				ang += ATAN_Q16[iter];
			end else begin
				x = x - ys;
				y = y + xs;
				ang -= ATAN_Q16[iter];
			end
		end
		return ang;
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'h7fff;
		end
		if (v < -32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic bit within_tolerance(input sample_t s);
		longint dx;
		longint dz;
		longint tol;
		dx = longint'($signed(m_target_x)) - longint'($signed(s.px));
		dz = longint'($signed(m_target_z)) - longint'($signed(s.pz));
		tol = longint'(m_tolerance);
		return dx * dx + dz * dz < tol * tol;
	endfunction

	// wheel command for one sample; latches the arrival flag
	function automatic wheel_cmd_t steer_from_sample(input sample_t s);
		longint dx;
		longint dz;
		longint diff;
		longint beta;
		longint term;
		wheel_cmd_t cmd;
		if (within_tolerance(s)) begin
			m_reached = 1'b1;
		end
		cmd = '{16'h0000, 16'h0000, 1'b1};
		if (m_reached) begin
			return cmd;
		end
		dx = longint'($signed(m_target_x)) - longint'($signed(s.px));
		dz = longint'($signed(m_target_z)) - longint'($signed(s.pz));
		diff = heading_q16(dz, dx)
			- heading_q16(longint'($signed(s.nz)), -longint'($signed(s.nx)));
		while (diff < 0) begin
			diff += TWO_PI_Q16;
		end
		while (diff >= TWO_PI_Q16) begin
			diff -= TWO_PI_Q16;
		end
		beta = diff - PI_Q16;
		term = (longint'(m_gain) * beta + 32) >>> 6;
		cmd.left_cmd = clamp16(longint'($signed(m_offset)) + term);
		cmd.right_cmd = clamp16(longint'($signed(m_offset)) - term);
		cmd.arrived = 1'b0;
		return cmd;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// drop any offered sample, wait until the block is empty, then write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_wheels.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET_X: m_target_x = data;
			CFG_TARGET_Z: m_target_z = data;
			CFG_TOLERANCE: m_tolerance = data[14:0];
			CFG_OFFSET: m_offset = data;
			CFG_GAIN: m_gain = data[3:0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input sample_t s, input bit typed, input wheel_cmd_t typed_cmd);
		wheel_cmd_t predicted;
		@(negedge clk);
		in_valid <= 1'b1;
		pos_x <= s.px;
		pos_z <= s.pz;
		north_x <= s.nx;
		north_z <= s.nz;
		do @(posedge clk); while (!in_ready);
		predicted = steer_from_sample(s);
		pending_wheels.push_back(typed ? typed_cmd : predicted);
		items_sent++;
	endtask

	// fresh: new random registers and samples kept clear of the target
	task automatic run_random(input int count, input bit fresh);
		sample_t s;
		int burst;
		int gap;
		int pick;
		int lim;
		int sent;
		if (fresh) begin
			write_reg(CFG_TARGET_X, 16'($urandom));
			write_reg(CFG_TARGET_Z, 16'($urandom));
			write_reg(CFG_TOLERANCE, {1'($urandom), 15'($urandom_range(0, 4000))});
			write_reg(CFG_OFFSET, 16'($urandom_range(0, 12000)) - 16'd6000);
			write_reg(CFG_GAIN, {12'($urandom), 4'($urandom_range(0, 15))});
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
			end
		end
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
			while (burst > 0 && sent < count) begin
				do begin
					pick = $urandom_range(0, 9);
					if (pick < 3) begin
						// close to the target: short vectors, zero vector when tolerance allows
						lim = 1 << $urandom_range(0, 10);
						s.px = 16'($signed(m_target_x) + lim - int'($urandom_range(0, 2 * lim)));
						s.pz = 16'($signed(m_target_z) + lim - int'($urandom_range(0, 2 * lim)));
					end else if (pick < 9) begin
						s.px = 16'($urandom);
						s.pz = 16'($urandom);
					end else begin
						s.px = CORNERS[$urandom_range(0, 3)];
						s.pz = CORNERS[$urandom_range(0, 3)];
					end
					pick = $urandom_range(0, 9);
					if (pick < 8) begin
						s.nx = 16'($urandom_range(0, 32768)) - 16'd16384;
						s.nz = 16'($urandom_range(0, 32768)) - 16'd16384;
					end else if (pick == 8) begin
						s.nx = CORNERS[$urandom_range(0, 3)];
						s.nz = CORNERS[$urandom_range(0, 3)];
					end else begin
						s.nx = 16'($urandom);
						s.nz = 16'($urandom);
					end
				end while (fresh && within_tolerance(s));
				send_item(s, 1'b0, '0);
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	initial begin
		plan_row_t row;
		sample_t s;
		int i;
		arst_n = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_z = '0;
		north_x = '0;
		north_z = '0;
		// assert reset once every process waits on it, ahead of the first clock edge
		#(HALF_PERIOD / 2);
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			s = '{row.px, row.pz, row.nx, row.nz};
			case (row.kind)
				ROW_WRITE: write_reg(row.idx, row.data);
				ROW_PREDICT: send_item(s, 1'b0, '0);
				ROW_TYPED: send_item(s, 1'b1, '{row.l, row.r, row.a});
				ROW_RANDOM: run_random(int'(row.data), 1'b1);
				ROW_TAIL: run_random(int'(row.data), 1'b0);
				default: ;
			endcase
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_wheels.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples and %0d register writes; %0d results checked.",
			items_sent, writes_done, results_seen);
		$display("Saturated commands: %0d; results with arrival set: %0d; mismatches: %0d.",
			saturated, arrivals_seen, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// receiver: mixes steady, coin-flip and sparse ready, plus one long hold-off
	initial begin
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int pick;
		bit held;
		out_ready = 1'b0;
		mode = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AT_RESULT) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					pick = $urandom_range(0, 3);
					mode = (pick >= 2) ? RX_STEADY : ((pick == 1) ? RX_COIN : RX_SPARSE);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					RX_STEADY: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_wheels.size() == 0) begin
				report_mismatch($sformatf("beat with nothing pending: left %0d right %0d arrived %0b",
					left_speed, right_speed, arrived));
			end else begin
				oldest = pending_wheels.pop_front();
				if (left_speed !== oldest.left_cmd) begin
					report_mismatch($sformatf("left_speed %0d, expected %0d",
						left_speed, $signed(oldest.left_cmd)));
				end
				if (right_speed !== oldest.right_cmd) begin
					report_mismatch($sformatf("right_speed %0d, expected %0d",
						right_speed, $signed(oldest.right_cmd)));
				end
				if (arrived !== oldest.arrived) begin
					report_mismatch($sformatf("arrived %0b, expected %0b", arrived, oldest.arrived));
				end
			end
			if (arrived === 1'b1) begin
				arrivals_seen++;
			end else if (left_speed == 16'sh7fff || left_speed == 16'sh8000
				|| right_speed == 16'sh7fff || right_speed == 16'sh8000) begin
				saturated++;
			end
			results_seen++;
		end
	end

	// end the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

endmodule
